FILE: design/lsr_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared sizes, operation and status codes, beat types and controller states
// for the LIFO stack with search and in-place reverse.
// ----------------------------------------------------------------------------
package lsr_pkg;

	// Storage geometry.
	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int FUNC_W = 3;
	localparam int IDX_W  = 6;
	localparam int STAT_W = 2;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_PUSH     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REVERSE  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_READ     = 3'd6;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Command beat.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] value;
		logic [IDX_W-1:0]  index;
	} cmd_t;

	// Result beat.
	typedef struct packed {
		logic [WORD_W-1:0] data_out;
		logic [STAT_W-1:0] status;
		logic              found;
		logic [CNT_W-1:0]  depth_used;
		logic              is_empty;
		logic              is_full;
	} rsp_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SRCH,
		S_REV_RLO,
		S_REV_RHI,
		S_REV_WLO,
		S_REV_WHI
	} state_t;

endpackage

FILE: design/lifo_stack_search_reverse.sv
// ----------------------------------------------------------------------------
// LIFO stack with search and reverse
// Push, clear and commands that need no memory read answer straight from idle
// and leave busy low, so the next can follow at once. Pop, peek and indexed read
// that find data pass through a read state; contains walks the entries until a
// hit or the last one; reverse swaps pairs from the ends inward (two reads and
// two writes per swapped pair); busy holds off the next command until their result.
// Reset clears the entry count and the controller; stored words stay undefined.
// ----------------------------------------------------------------------------
module lifo_stack_search_reverse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lsr_pkg::cmd_t cmd,
	output logic          done,
	output lsr_pkg::rsp_t rsp
);

	lsr_pkg::state_t state_q, state_d;

	logic [lsr_pkg::CNT_W-1:0]  count_q, count_d;
	logic                       accept;
	logic                       empty, full;
	logic                       idx_ok;

	// Memory port signals.
	logic [lsr_pkg::WORD_W-1:0] mem [lsr_pkg::DEPTH];
	logic                       mem_we;
	logic [lsr_pkg::ADDR_W-1:0] mem_wa, mem_ra;
	logic [lsr_pkg::WORD_W-1:0] mem_wd;
	logic [lsr_pkg::WORD_W-1:0] mem_rd_s1;

	// Search and reverse walk registers.
	logic [lsr_pkg::WORD_W-1:0] key_q;
	logic [lsr_pkg::CNT_W-1:0]  ptr_q;
	logic                       rd_v_s1, last_s1;
	logic                       issue, hit, srch_done;
	logic [lsr_pkg::ADDR_W-1:0] lo_q, hi_q;
	logic [lsr_pkg::WORD_W-1:0] tmp_q;
	logic                       rev_more;

	// Result registers.
	logic                       load;
	logic [lsr_pkg::WORD_W-1:0] data_d, data_q;
	logic [lsr_pkg::STAT_W-1:0] status_d, status_q;
	logic                       found_d, found_q;
	logic                       done_q;

	// Handshake and occupancy flags.
	assign busy   = (state_q != lsr_pkg::S_IDLE);
	assign accept = start && !busy;
	assign empty  = (count_q == '0);
	assign full   = (count_q == lsr_pkg::CNT_W'(lsr_pkg::DEPTH));
	assign idx_ok = (lsr_pkg::CNT_W'(cmd.index) < count_q);

	// Search pipeline: one read issued per cycle, compared once the registered read returns.
	assign issue     = (ptr_q < count_q);
	assign hit       = (mem_rd_s1 == key_q);
	assign srch_done = rd_v_s1 && (hit || last_s1);

	// Another pair remains when lo + 1 < hi - 1.
	assign rev_more = ((lsr_pkg::CNT_W'(lo_q) + lsr_pkg::CNT_W'(2)) < lsr_pkg::CNT_W'(hi_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsr_pkg::S_IDLE: begin
				if (accept) begin
					priority case (cmd.func)
						lsr_pkg::FN_POP, lsr_pkg::FN_PEEK: begin
							if (!empty) state_d = lsr_pkg::S_READ;
						end
						lsr_pkg::FN_READ: begin
							if (idx_ok) state_d = lsr_pkg::S_READ;
						end
						lsr_pkg::FN_CONTAINS: begin
							if (!empty) state_d = lsr_pkg::S_SRCH;
						end
						lsr_pkg::FN_REVERSE: begin
							if (count_q >= lsr_pkg::CNT_W'(2)) state_d = lsr_pkg::S_REV_RLO;
						end
						default: state_d = lsr_pkg::S_IDLE;
					endcase
				end
			end
			lsr_pkg::S_READ:    state_d = lsr_pkg::S_IDLE;
			lsr_pkg::S_SRCH: begin
				if (srch_done) state_d = lsr_pkg::S_IDLE;
			end
			lsr_pkg::S_REV_RLO: state_d = lsr_pkg::S_REV_RHI;
			lsr_pkg::S_REV_RHI: state_d = lsr_pkg::S_REV_WLO;
			lsr_pkg::S_REV_WLO: state_d = lsr_pkg::S_REV_WHI;
			lsr_pkg::S_REV_WHI: state_d = rev_more ? lsr_pkg::S_REV_RLO : lsr_pkg::S_IDLE;
			default:            state_d = lsr_pkg::S_IDLE;
		endcase
	end

	// Memory controls, count update and result selection.
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = count_q[lsr_pkg::ADDR_W-1:0];
		mem_wd   = cmd.value;
		mem_ra   = ptr_q[lsr_pkg::ADDR_W-1:0];
		count_d  = count_q;
		load     = 1'b0;
		data_d   = '0;
		status_d = lsr_pkg::ST_OK;
		found_d  = 1'b0;
		unique case (state_q)
			lsr_pkg::S_IDLE: begin
				if (accept) begin
					priority case (cmd.func)
						lsr_pkg::FN_PUSH: begin
							load = 1'b1;
							if (full) begin
								status_d = lsr_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + lsr_pkg::CNT_W'(1);
							end
						end
						lsr_pkg::FN_POP: begin
							mem_ra = lsr_pkg::ADDR_W'(count_q - lsr_pkg::CNT_W'(1));
							if (empty) begin
								load     = 1'b1;
								status_d = lsr_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - lsr_pkg::CNT_W'(1);
							end
						end
						lsr_pkg::FN_PEEK: begin
							mem_ra = lsr_pkg::ADDR_W'(count_q - lsr_pkg::CNT_W'(1));
							if (empty) begin
								load     = 1'b1;
								status_d = lsr_pkg::ST_EMPTY;
							end
						end
						lsr_pkg::FN_CLEAR: begin
							load    = 1'b1;
							count_d = '0;
						end
						lsr_pkg::FN_CONTAINS: begin
							if (empty) load = 1'b1;
						end
						lsr_pkg::FN_REVERSE: begin
							if (count_q < lsr_pkg::CNT_W'(2)) load = 1'b1;
						end
						lsr_pkg::FN_READ: begin
							mem_ra = lsr_pkg::ADDR_W'(cmd.index);
							if (!idx_ok) begin
								load     = 1'b1;
								status_d = lsr_pkg::ST_RANGE;
							end
						end
						default: load = 1'b1;
					endcase
				end
			end
			lsr_pkg::S_READ: begin
				load   = 1'b1;
				data_d = mem_rd_s1;
			end
			lsr_pkg::S_SRCH: begin
				if (srch_done) begin
					load    = 1'b1;
					found_d = hit;
				end
			end
			lsr_pkg::S_REV_RLO: mem_ra = lo_q;
			lsr_pkg::S_REV_RHI: mem_ra = hi_q;
			lsr_pkg::S_REV_WLO: begin
				mem_we = 1'b1;
				mem_wa = lo_q;
				mem_wd = mem_rd_s1;
			end
			lsr_pkg::S_REV_WHI: begin
				mem_we = 1'b1;
				mem_wa = hi_q;
				mem_wd = tmp_q;
				if (!rev_more) load = 1'b1;
			end
			default: load = 1'b0;
		endcase
	end

	// Entry storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_s1 <= mem[mem_ra];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsr_pkg::S_IDLE;
			count_q <= '0;
			rd_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_v_s1 <= (state_q == lsr_pkg::S_SRCH) && issue && !srch_done;
			done_q  <= load;
		end
	end

	// Walk pointers, search key and swap buffer.
	always_ff @(posedge clk) begin
		last_s1 <= (ptr_q == (count_q - lsr_pkg::CNT_W'(1)));
		if (accept) begin
			key_q <= cmd.value;
			ptr_q <= '0;
			lo_q  <= '0;
			hi_q  <= lsr_pkg::ADDR_W'(count_q - lsr_pkg::CNT_W'(1));
		end else if (state_q == lsr_pkg::S_SRCH && issue) begin
			ptr_q <= ptr_q + lsr_pkg::CNT_W'(1);
		end else if (state_q == lsr_pkg::S_REV_WHI) begin
			lo_q <= lo_q + lsr_pkg::ADDR_W'(1);
			hi_q <= hi_q - lsr_pkg::ADDR_W'(1);
		end
		if (state_q == lsr_pkg::S_REV_RHI) tmp_q <= mem_rd_s1;
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= data_d;
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

	// The count has already settled when the result beat is shown.
	assign done           = done_q;
	assign rsp.data_out   = data_q;
	assign rsp.status     = status_q;
	assign rsp.found      = found_q;
	assign rsp.depth_used = count_q;
	assign rsp.is_empty   = empty;
	assign rsp.is_full    = full;

endmodule

FILE: design/lsr_checker.sv
// ----------------------------------------------------------------------------
// LIFO stack port checker
// Watches the command and result ports of the LIFO stack for consistency.
// ----------------------------------------------------------------------------
module lsr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input lsr_pkg::cmd_t cmd,
	input logic          done,
	input lsr_pkg::rsp_t rsp
);

	// A push always answers in the following cycle.
	a_push_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == lsr_pkg::FN_PUSH) |=> done)
		else $error("push beat not answered in the next cycle");

	// A result beat appears only once the controller is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Flags agree with the count.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.is_empty == (rsp.depth_used == '0)) &&
		          (rsp.is_full == (rsp.depth_used == lsr_pkg::CNT_W'(lsr_pkg::DEPTH)))))
		else $error("empty or full flag disagrees with depth_used");

	// An underflow leaves the stack empty and returns no data.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == lsr_pkg::ST_EMPTY) |-> (rsp.is_empty && rsp.data_out == '0))
		else $error("underflow result with data or stored entries");

endmodule

bind lifo_stack_search_reverse lsr_checker u_lsr_checker (.*);
